FILE: src/sta_pkg.sv
// ----------------------------------------------------------------------------
// sta_pkg
// Shared types and constants of the separated time slot allocator.
// ----------------------------------------------------------------------------
package sta_pkg;

    // field widths fixed by the interface
    localparam int TIME_W = 32;
    localparam int SEP_W  = 16;
    localparam int USED_W = 5;

    // separation after reset, in seconds
    localparam logic [SEP_W-1:0] SEP_RESET = 16'd60;

    // request sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIRST,
        ST_WALK,
        ST_LAST,
        ST_PURGE_START,
        ST_PURGE,
        ST_INS_START,
        ST_INS,
        ST_INS_LAST,
        ST_DONE
    } state_t;

endpackage

FILE: src/sta_ram.sv
// ----------------------------------------------------------------------------
// sta_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: src/separated_time_slot_allocator_core.sv
// ----------------------------------------------------------------------------
// separated_time_slot_allocator_core
// Grants slot times that keep a minimum separation from a sorted slot table.
// ----------------------------------------------------------------------------
// Each request carries a requested time and the current time and returns one
// result: the granted time, a flag set when the table was full and the grant
// was dropped, and the number of stored slots afterward. The table is kept
// sorted in a single-port-read RAM used as a ring (a purge only moves the
// head), and one sequencer walks it entry by entry with one shared saturating
// adder: a gap walk to pick the grant, a purge scan of stale entries and an
// insertion that shifts larger entries up one place while it searches from
// the top. Each step of the sequencer makes one RAM read, and the input is not
// ready from an accepted request until its result is handed to the output
// register, which waits while the previous result still sits unread.
// A finished result waits in an output register.
// ----------------------------------------------------------------------------
module separated_time_slot_allocator_core #(
    parameter int SLOT_CAPACITY = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // separation register write
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] requested_time, [63:32] current_time
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] granted_time, [36:32] slots_used, rest 0
    output logic        m_axis_tuser    // [0] not_stored
);

    localparam int IDX_W = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
    localparam int CNT_W = $clog2(SLOT_CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [SUM_W-1:0] CAP_S = SUM_W'(SLOT_CAPACITY);
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(SLOT_CAPACITY);
    localparam logic [sta_pkg::USED_W-1:0] CAP_USED = sta_pkg::USED_W'(SLOT_CAPACITY);

    // ring position of a logical table index
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] lidx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(lidx);
        if (sum >= CAP_S)
        begin
            sum = sum - CAP_S;
        end
        return sum[IDX_W-1:0];
    endfunction

    sta_pkg::state_t state_reg, state_next;

    logic [sta_pkg::SEP_W-1:0]  sep_reg;
    logic [sta_pkg::TIME_W-1:0] req_reg, req_next;
    logic [sta_pkg::TIME_W-1:0] now_reg, now_next;
    logic [sta_pkg::TIME_W-1:0] lo_reg, lo_next;
    logic [sta_pkg::TIME_W-1:0] grant_reg, grant_next;
    logic                       ns_reg, ns_next;
    logic [CNT_W-1:0]           idx_reg, idx_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [IDX_W-1:0]           head_reg, head_next;

    logic                       out_valid_reg, out_valid_next;
    logic [sta_pkg::TIME_W-1:0] out_grant_reg, out_grant_next;
    logic                       out_ns_reg, out_ns_next;
    logic [sta_pkg::USED_W-1:0] out_used_reg, out_used_next;

    logic                       ram_we;
    logic [CNT_W-1:0]           wr_lidx;
    logic [CNT_W-1:0]           rd_lidx;
    logic [sta_pkg::TIME_W-1:0] ram_wdata;
    logic [sta_pkg::TIME_W-1:0] rd_data;
    logic [IDX_W-1:0]           wr_addr;
    logic [IDX_W-1:0]           rd_addr;

    logic [sta_pkg::TIME_W-1:0] add_a;
    logic [sta_pkg::TIME_W:0]   add_sum;
    logic [sta_pkg::TIME_W-1:0] add_sat;
    logic [sta_pkg::TIME_W-1:0] pair_diff;
    logic [sta_pkg::TIME_W-1:0] gap;
    logic [31:0]                cnt_ext;
    logic [CNT_W-1:0]           kept;
    logic                       in_accept;
    logic                       out_free;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !out_valid_reg || m_axis_tready;

    // shared saturating adder: request or lower entry plus separation
    assign add_a   = (state_reg == sta_pkg::ST_FIRST) ? req_reg : lo_reg;
    assign add_sum = {1'b0, add_a} + (sta_pkg::TIME_W + 1)'(sep_reg);
    assign add_sat = add_sum[sta_pkg::TIME_W] ? '1 : add_sum[sta_pkg::TIME_W-1:0];

    // pair gap against twice the separation
    assign pair_diff = rd_data - lo_reg;
    assign gap       = sta_pkg::TIME_W'({sep_reg, 1'b0});

    // entries left after the purge scan
    assign kept = count_reg - idx_reg;

    assign cnt_ext = 32'(count_reg);

    assign wr_addr = phys(head_reg, wr_lidx);
    assign rd_addr = phys(head_reg, rd_lidx);

    sta_ram #(
        .WIDTH (sta_pkg::TIME_W),
        .DEPTH (SLOT_CAPACITY)
    ) u_slots (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_addr),
        .wr_data (ram_wdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // separation register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg <= sta_pkg::SEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            sep_reg <= cfg_wr_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sta_pkg::ST_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        now_reg       <= now_next;
        lo_reg        <= lo_next;
        grant_reg     <= grant_next;
        ns_reg        <= ns_next;
        idx_reg       <= idx_next;
        out_grant_reg <= out_grant_next;
        out_ns_reg    <= out_ns_next;
        out_used_reg  <= out_used_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        now_next       = now_reg;
        lo_next        = lo_reg;
        grant_next     = grant_reg;
        ns_next        = ns_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_grant_next = out_grant_reg;
        out_ns_next    = out_ns_reg;
        out_used_next  = out_used_reg;
        ram_we         = 1'b0;
        wr_lidx        = '0;
        rd_lidx        = '0;
        ram_wdata      = grant_reg;

        unique case (state_reg)
            sta_pkg::ST_IDLE:
            begin
                // read of the first entry goes out with the request
                rd_lidx = '0;
                if (in_accept)
                begin
                    req_next = s_axis_tdata[31:0];
                    now_next = s_axis_tdata[63:32];
                    if (count_reg == '0)
                    begin
                        // empty table: store as is, no purge
                        ram_we     = 1'b1;
                        wr_lidx    = '0;
                        ram_wdata  = s_axis_tdata[31:0];
                        grant_next = s_axis_tdata[31:0];
                        ns_next    = 1'b0;
                        count_next = CNT_W'(1);
                        state_next = sta_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = sta_pkg::ST_FIRST;
                    end
                end
            end

            sta_pkg::ST_FIRST:
            begin
                rd_lidx = CNT_W'(1);
                if (add_sat < rd_data)
                begin
                    // early request fits ahead of the first slot
                    grant_next = req_reg;
                    state_next = sta_pkg::ST_PURGE_START;
                end
                else
                begin
                    lo_next  = rd_data;
                    idx_next = '0;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = sta_pkg::ST_LAST;
                    end
                    else
                    begin
                        state_next = sta_pkg::ST_WALK;
                    end
                end
            end

            sta_pkg::ST_WALK:
            begin
                // rd_data is the upper entry of the pair, next one is fetched
                rd_lidx = idx_reg + CNT_W'(2);
                if ((pair_diff > gap) && (req_reg > lo_reg) && (req_reg < rd_data))
                begin
                    grant_next = (req_reg < add_sat) ? add_sat : req_reg;
                    state_next = sta_pkg::ST_PURGE_START;
                end
                else if ((pair_diff > gap) && (req_reg < lo_reg))
                begin
                    grant_next = add_sat;
                    state_next = sta_pkg::ST_PURGE_START;
                end
                else
                begin
                    lo_next  = rd_data;
                    idx_next = idx_reg + CNT_W'(1);
                    if (({1'b0, idx_reg} + SUM_W'(2)) >= {1'b0, count_reg})
                    begin
                        state_next = sta_pkg::ST_LAST;
                    end
                end
            end

            sta_pkg::ST_LAST:
            begin
                // past the last entry
                grant_next = (add_sat < req_reg) ? req_reg : add_sat;
                state_next = sta_pkg::ST_PURGE_START;
            end

            sta_pkg::ST_PURGE_START:
            begin
                rd_lidx    = '0;
                idx_next   = '0;
                state_next = sta_pkg::ST_PURGE;
            end

            sta_pkg::ST_PURGE:
            begin
                // rd_data holds entry idx, the following one is fetched
                rd_lidx = idx_reg + CNT_W'(1);
                if ((idx_reg < count_reg) && (rd_data < now_reg))
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    head_next  = phys(head_reg, idx_reg);
                    count_next = kept;
                    if (grant_reg < now_reg)
                    begin
                        ns_next    = 1'b0;
                        state_next = sta_pkg::ST_DONE;
                    end
                    else if (kept >= CAP_C)
                    begin
                        ns_next    = 1'b1;
                        state_next = sta_pkg::ST_DONE;
                    end
                    else if (kept == '0)
                    begin
                        // everything purged: grant becomes the only entry
                        ram_we     = 1'b1;
                        wr_lidx    = idx_reg;
                        ram_wdata  = grant_reg;
                        ns_next    = 1'b0;
                        count_next = CNT_W'(1);
                        state_next = sta_pkg::ST_DONE;
                    end
                    else
                    begin
                        ns_next    = 1'b0;
                        state_next = sta_pkg::ST_INS_START;
                    end
                end
            end

            sta_pkg::ST_INS_START:
            begin
                rd_lidx    = count_reg - CNT_W'(1);
                idx_next   = count_reg;
                state_next = sta_pkg::ST_INS;
            end

            sta_pkg::ST_INS:
            begin
                // rd_data holds entry idx-1; shift it up while above the grant
                rd_lidx = idx_reg - CNT_W'(2);
                ram_we  = 1'b1;
                wr_lidx = idx_reg;
                if (rd_data > grant_reg)
                begin
                    ram_wdata = rd_data;
                    idx_next  = idx_reg - CNT_W'(1);
                    if (idx_reg == CNT_W'(1))
                    begin
                        state_next = sta_pkg::ST_INS_LAST;
                    end
                end
                else
                begin
                    ram_wdata  = grant_reg;
                    count_next = count_reg + CNT_W'(1);
                    state_next = sta_pkg::ST_DONE;
                end
            end

            sta_pkg::ST_INS_LAST:
            begin
                ram_we     = 1'b1;
                wr_lidx    = '0;
                ram_wdata  = grant_reg;
                count_next = count_reg + CNT_W'(1);
                state_next = sta_pkg::ST_DONE;
            end

            sta_pkg::ST_DONE:
            begin
                // hand the result to the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_grant_next = grant_reg;
                    out_ns_next    = ns_reg;
                    out_used_next  = cnt_ext[sta_pkg::USED_W-1:0];
                    state_next     = sta_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = sta_pkg::ST_IDLE;
            end
        endcase
    end

    // ports
    assign s_axis_tready = (state_reg == sta_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_used_reg, out_grant_reg};
    assign m_axis_tuser  = out_ns_reg;

    // a request always leaves idle
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == sta_pkg::ST_FIRST) || (state_reg == sta_pkg::ST_DONE))
        else $error("request accepted but sequencer did not start");

    // table writes only on an empty-table store, full purge or insertion
    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == sta_pkg::ST_IDLE) || (state_reg == sta_pkg::ST_PURGE) ||
                   (state_reg == sta_pkg::ST_INS) || (state_reg == sta_pkg::ST_INS_LAST))
        else $error("slot table written outside a store phase");

    // count never exceeds the capacity
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("slot count above capacity");

    // a dropped grant is reported only with a full table
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (out_used_reg == CAP_USED))
        else $error("grant dropped while table not full");

    // insertion never grows the table past the capacity
    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sta_pkg::ST_INS_START) |-> (count_reg < CAP_C))
        else $error("insertion started on a full table");

endmodule
